/* hw/rtl/jbbc_pkg.sv */
// Shared types and character constants for the JSON bracket balance checker.
`default_nettype none

package jbbc_pkg;

    // Characters that the scanner recognizes.
    localparam logic [7:0] CHAR_OPEN_BRACE   = 8'h7B;
    localparam logic [7:0] CHAR_OPEN_SQUARE  = 8'h5B;
    localparam logic [7:0] CHAR_CLOSE_BRACE  = 8'h7D;
    localparam logic [7:0] CHAR_CLOSE_SQUARE = 8'h5D;
    localparam logic [7:0] CHAR_QUOTE        = 8'h22;
    localparam logic [7:0] CHAR_BACKSLASH    = 8'h5C;

    // Depth limit after reset.
    localparam logic [7:0] DEPTH_LIMIT_RESET = 8'd100;

    // Kind of an open bracket as stored on the stack.
    localparam logic KIND_BRACE  = 1'b0;
    localparam logic KIND_SQUARE = 1'b1;

    // Status reported with every byte.
    typedef enum logic [1:0] {
        VERDICT_PENDING = 2'd0,
        VERDICT_VALID   = 2'd1,
        VERDICT_INVALID = 2'd2
    } verdict_t;

    // One result word.
    typedef struct packed {
        verdict_t   verdict;
        logic [7:0] nesting_depth;
    } result_t;

endpackage : jbbc_pkg

`default_nettype wire

/* hw/rtl/jbbc_stack_mem.sv */
// Bracket kind stack memory: one write port, one registered read port.
`default_nettype none

module jbbc_stack_mem #(
    parameter int DEPTH = 128,
    parameter int AW    = 7
) (
    input  wire logic          clk,
    input  wire logic          wr_en,
    input  wire logic [AW-1:0] wr_addr,
    input  wire logic          wr_kind,
    input  wire logic          rd_en,
    input  wire logic [AW-1:0] rd_addr,
    output logic               rd_kind
);

    logic mem [DEPTH];
    logic rd_kind_reg;

    // Write port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_kind;
        end
    end

    // Read port; the data holds until the next read.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_kind_reg <= mem[rd_addr];
        end
    end

    assign rd_kind = rd_kind_reg;

endmodule : jbbc_stack_mem

`default_nettype wire

/* hw/rtl/jbbc_core.sv */
// Byte scanner: string and escape tracking, stack pointer, top-of-stack and error state.
`default_nettype none

module jbbc_core #(
    parameter int STACK_ENTRIES = 128,
    parameter int AW            = 7,
    parameter int LW            = 8
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              accept,
    input  wire logic [7:0]        text_byte,
    input  wire logic              end_of_document,
    input  wire logic [7:0]        depth_limit,
    output logic                   mem_wr_en,
    output logic [AW-1:0]          mem_wr_addr,
    output logic                   mem_wr_kind,
    output logic                   mem_rd_en,
    output logic [AW-1:0]          mem_rd_addr,
    input  wire logic              mem_rd_kind,
    output jbbc_pkg::result_t      result
);

    localparam int CMPW = ((LW > 8) ? LW : 8) + 1;

    logic [LW-1:0] level_reg, level_next;
    logic          str_reg, str_next;
    logic          esc_reg, esc_next;
    logic          err_reg, err_next;
    logic          pend_reg, pend_next;
    logic          top_reg, top_next;

    logic          top_kind;
    logic          is_open;
    logic          is_close;
    logic          want_kind;
    logic          at_limit;
    logic [CMPW-1:0] level_ext;
    logic [CMPW-1:0] limit_ext;
    logic [CMPW-1:0] depth_ext;

    // After a pop the top entry comes from memory until the next byte is accepted, else from the register.
    assign top_kind  = pend_reg ? mem_rd_kind : top_reg;
    assign is_open   = (text_byte == jbbc_pkg::CHAR_OPEN_BRACE)
                    || (text_byte == jbbc_pkg::CHAR_OPEN_SQUARE);
    assign is_close  = (text_byte == jbbc_pkg::CHAR_CLOSE_BRACE)
                    || (text_byte == jbbc_pkg::CHAR_CLOSE_SQUARE);
    assign want_kind = (text_byte == jbbc_pkg::CHAR_CLOSE_SQUARE) ? jbbc_pkg::KIND_SQUARE
                                                                  : jbbc_pkg::KIND_BRACE;
    assign level_ext = CMPW'(level_reg);
    assign limit_ext = CMPW'(depth_limit);
    assign at_limit  = (level_ext >= limit_ext) || (level_reg >= LW'(STACK_ENTRIES));

    // Next state for one accepted byte.
    always_comb
    begin
        level_next  = level_reg;
        str_next    = str_reg;
        esc_next    = esc_reg;
        err_next    = err_reg;
        pend_next   = 1'b0;
        top_next    = top_kind;
        mem_wr_en   = 1'b0;
        mem_wr_addr = AW'(level_reg);
        mem_wr_kind = (text_byte == jbbc_pkg::CHAR_OPEN_SQUARE) ? jbbc_pkg::KIND_SQUARE
                                                                : jbbc_pkg::KIND_BRACE;
        mem_rd_en   = 1'b0;
        mem_rd_addr = AW'(level_reg - LW'(2));

        if (accept && !err_reg)
        begin
            if (esc_reg)
            begin
                esc_next = 1'b0;
            end
            else if (str_reg && (text_byte == jbbc_pkg::CHAR_BACKSLASH))
            begin
                esc_next = 1'b1;
            end
            else if (text_byte == jbbc_pkg::CHAR_QUOTE)
            begin
                str_next = !str_reg;
            end
            else if (!str_reg && is_open)
            begin
                if (at_limit)
                begin
                    err_next = 1'b1;
                end
                else
                begin
                    mem_wr_en  = 1'b1;
                    top_next   = mem_wr_kind;
                    level_next = level_reg + LW'(1);
                end
            end
            else if (!str_reg && is_close)
            begin
                if ((level_reg == '0) || (top_kind != want_kind))
                begin
                    err_next = 1'b1;
                end
                else
                begin
                    // Fetch the entry that becomes the new top.
                    level_next = level_reg - LW'(1);
                    mem_rd_en  = (level_reg > LW'(1));
                    pend_next  = 1'b1;
                end
            end
        end

        if (!accept)
        begin
            pend_next = pend_reg;
            top_next  = top_reg;
        end
    end

    assign depth_ext = CMPW'(level_next);

    // Result of the byte, taken before the clear on the final byte.
    always_comb
    begin
        result.nesting_depth = depth_ext[7:0];
        if (end_of_document)
        begin
            result.verdict = (!err_next && (level_next == '0) && !str_next)
                           ? jbbc_pkg::VERDICT_VALID : jbbc_pkg::VERDICT_INVALID;
        end
        else
        begin
            result.verdict = err_next ? jbbc_pkg::VERDICT_INVALID : jbbc_pkg::VERDICT_PENDING;
        end
    end

    // Control state; a final byte returns everything to the reset values.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            level_reg <= '0;
            str_reg   <= 1'b0;
            esc_reg   <= 1'b0;
            err_reg   <= 1'b0;
            pend_reg  <= 1'b0;
        end
        else if (accept && end_of_document)
        begin
            level_reg <= '0;
            str_reg   <= 1'b0;
            esc_reg   <= 1'b0;
            err_reg   <= 1'b0;
            pend_reg  <= 1'b0;
        end
        else
        begin
            level_reg <= level_next;
            str_reg   <= str_next;
            esc_reg   <= esc_next;
            err_reg   <= err_next;
            pend_reg  <= pend_next;
        end
    end

    // Cached top-of-stack kind.
    always_ff @(posedge clk)
    begin
        top_reg <= top_next;
    end

endmodule : jbbc_core

`default_nettype wire

/* hw/rtl/jbbc_out_skid.sv */
// Output register with a skid stage so the input side never waits on a combinational stall.
`default_nettype none

module jbbc_out_skid (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_word_valid,
    input  wire jbbc_pkg::result_t  in_word,
    output logic                    in_full,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output jbbc_pkg::result_t       out_word
);

    logic              main_valid_reg, main_valid_next;
    logic              skid_valid_reg, skid_valid_next;
    jbbc_pkg::result_t main_reg, main_next;
    jbbc_pkg::result_t skid_reg, skid_next;
    logic              main_free;

    assign main_free = !main_valid_reg || !out_stall;

    // Move words forward: skid first, then a new word.
    always_comb
    begin
        main_valid_next = main_valid_reg;
        skid_valid_next = skid_valid_reg;
        main_next       = main_reg;
        skid_next       = skid_reg;
        if (main_free)
        begin
            if (skid_valid_reg)
            begin
                main_valid_next = 1'b1;
                main_next       = skid_reg;
                skid_valid_next = 1'b0;
            end
            else
            begin
                main_valid_next = in_word_valid;
                main_next       = in_word;
            end
        end
        else if (in_word_valid)
        begin
            skid_valid_next = 1'b1;
            skid_next       = in_word;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            main_valid_reg <= main_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        main_reg <= main_next;
        skid_reg <= skid_next;
    end

    assign in_full   = skid_valid_reg;
    assign out_valid = main_valid_reg;
    assign out_word  = main_reg;

endmodule : jbbc_out_skid

`default_nettype wire

/* hw/rtl/json_bracket_balance_checker.sv */
// Top level of the JSON bracket balance checker.
// Takes one byte of a JSON document per cycle while not stalled and returns one status word
// per byte: the verdict (pending, valid on the final byte, or invalid) and the nesting depth
// after the byte. Braces and brackets outside strings are kept on a stack in a single-port-read
// memory; a pop reads the new top from memory and the next accepted byte uses it through a
// cached top-of-stack path, so bytes stream at one per cycle unless stalled; each status word
// is registered in the output stage. A two-word output skid stage lets the input keep flowing
// while a word is stalled. The depth limit register is to be written only while the block is
// idle (the block itself does not enforce this); the final byte of each document clears all scan state.
`default_nettype none

module json_bracket_balance_checker #(
    parameter int STACK_ENTRIES = 128
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_stall,
    input  wire logic [7:0] text_byte,
    input  wire logic       end_of_document,
    output logic            out_valid,
    input  wire logic       out_stall,
    output logic [1:0]      verdict,
    output logic [7:0]      nesting_depth,
    input  wire logic       cfg_valid,
    output logic            cfg_ready,
    input  wire logic [7:0] cfg_data
);

    localparam int AW = (STACK_ENTRIES > 1) ? $clog2(STACK_ENTRIES) : 1;
    localparam int LW = $clog2(STACK_ENTRIES + 1);

    logic              accept;
    logic [7:0]        depth_limit_reg;
    logic              mem_wr_en;
    logic [AW-1:0]     mem_wr_addr;
    logic              mem_wr_kind;
    logic              mem_rd_en;
    logic [AW-1:0]     mem_rd_addr;
    logic              mem_rd_kind;
    jbbc_pkg::result_t core_result;
    jbbc_pkg::result_t out_word;
    logic              skid_full;

    assign accept    = in_valid && !in_stall;
    assign in_stall  = skid_full;
    assign cfg_ready = 1'b1;

    // Depth limit register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            depth_limit_reg <= jbbc_pkg::DEPTH_LIMIT_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            depth_limit_reg <= cfg_data;
        end
    end

    jbbc_stack_mem #(
        .DEPTH (STACK_ENTRIES),
        .AW    (AW)
    ) u_stack_mem (
        .clk     (clk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_kind (mem_wr_kind),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_kind (mem_rd_kind)
    );

    jbbc_core #(
        .STACK_ENTRIES (STACK_ENTRIES),
        .AW            (AW),
        .LW            (LW)
    ) u_core (
        .clk             (clk),
        .rst_n           (rst_n),
        .accept          (accept),
        .text_byte       (text_byte),
        .end_of_document (end_of_document),
        .depth_limit     (depth_limit_reg),
        .mem_wr_en       (mem_wr_en),
        .mem_wr_addr     (mem_wr_addr),
        .mem_wr_kind     (mem_wr_kind),
        .mem_rd_en       (mem_rd_en),
        .mem_rd_addr     (mem_rd_addr),
        .mem_rd_kind     (mem_rd_kind),
        .result          (core_result)
    );

    jbbc_out_skid u_out_skid (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_word_valid (accept),
        .in_word       (core_result),
        .in_full       (skid_full),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .out_word      (out_word)
    );

    assign verdict       = out_word.verdict;
    assign nesting_depth = out_word.nesting_depth;

    // A document reported valid has an empty stack.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (verdict == jbbc_pkg::VERDICT_VALID)) |-> (nesting_depth == 8'd0))
    else $error("valid verdict with nonzero depth");

    // The input side only waits while a word is held for the output.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid)
    else $error("input stalled with empty output");

    // A word can only be parked in the skid stage when the output was stalled.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(in_stall) |-> $past(out_valid && out_stall && accept))
    else $error("skid stage filled without an output stall");

endmodule : json_bracket_balance_checker

`default_nettype wire
